// ===== design/vita49_data_header_parser_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the VITA-49 data header parser.
// ---------------------------------------------------------------------------
`ifndef VITA49_DATA_HEADER_PARSER_TOP_DEFINES_SVH
`define VITA49_DATA_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define VDHP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("vdhp assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define VDHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vdhp assertion failed");
`else
`define VDHP_ASSERT(lbl, clk, rst_n, prop)
`define VDHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/vdhp_pkg.sv =====
// ---------------------------------------------------------------------------
// vdhp_pkg
// Types and constants of the VITA-49 IF data packet header parser.
// ---------------------------------------------------------------------------
package vdhp_pkg;

	localparam logic [31:0] TYPE_MASK   = 32'hF000_0000;
	localparam logic [31:0] TYPE_IFSID  = 32'h1000_0000;
	localparam logic [31:0] CLASS_BIT   = 32'h0800_0000;
	localparam logic [31:0] TRAILER_BIT = 32'h0400_0000;
	localparam logic [31:0] TSI_MASK    = 32'h00C0_0000;
	localparam logic [31:0] TSF_MASK    = 32'h0030_0000;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [0:0] {
		REG_VENDOR_OUI = 1'b0,
		REG_INFO_CLASS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic        last;
		logic [2:0]  last_bytes;
	} packet_in_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] stream_id;
		logic [15:0] packet_class;
		logic [3:0]  packet_count;
		logic [4:0]  payload_offset;
		logic [15:0] payload_bytes;
	} result_t;

	// Everything the back end needs to judge one datagram.
	typedef struct packed {
		logic [15:0] total;
		logic [31:0] header;
		logic [31:0] stream;
		logic        oui_match;
		logic [31:0] class_low;
	} datagram_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== design/vita49_data_header_parser_top.sv =====
// ---------------------------------------------------------------------------
// vita49_data_header_parser_top
// VITA-49 IF data packet header parser: one verdict per datagram.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       vdhp_pkg::packet_in_t
// out       output     out_valid / out_ready     vdhp_pkg::result_t
// cfg       input      cfg_we                    cfg_index, cfg_data
//
// One word is taken per clock while in_ready is high. The verdict for a
// datagram is registered in the output register when its record is popped.
// A two-entry record queue sits between the word counter and the verdict
// stage; in_ready drops only while that queue is full.
// Reset clears the byte count, captured header words, queue and registers.
// ---------------------------------------------------------------------------
module vita49_data_header_parser_top #(
	parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vdhp_pkg::packet_in_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vdhp_pkg::result_t    out_data,
	input  logic                 cfg_we,
	input  vdhp_pkg::cfg_reg_t   cfg_index,
	input  logic [23:0]          cfg_data
);

	logic [23:0]             vendor_oui_q;
	logic [15:0]             info_class_q;
	logic                    accept;
	logic                    push;
	logic                    pop;
	vdhp_pkg::datagram_rec_t push_rec;
	vdhp_pkg::datagram_rec_t head;
	vdhp_pkg::queue_stat_t   qstat;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_oui_q <= '0;
			info_class_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				vdhp_pkg::REG_VENDOR_OUI: vendor_oui_q <= cfg_data;
				vdhp_pkg::REG_INFO_CLASS: info_class_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	vdhp_front #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.word      (in_data),
		.vendor_oui(vendor_oui_q),
		.push      (push),
		.rec       (push_rec)
	);

	vdhp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head    (head),
		.stat    (qstat)
	);

	vdhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (head),
		.qstat     (qstat),
		.info_class(info_class_q),
		.pop       (pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (out_data)
	);

endmodule

// ===== design/vdhp_front.sv =====
// ---------------------------------------------------------------------------
// vdhp_front
// Counts datagram bytes, captures the header words and hands a record of
// each finished datagram to the queue.
// ---------------------------------------------------------------------------
`include "vita49_data_header_parser_top_defines.svh"

module vdhp_front #(
	parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  vdhp_pkg::packet_in_t   word,
	input  logic [23:0]            vendor_oui,
	output logic                   push,
	output vdhp_pkg::datagram_rec_t rec
);

	localparam int unsigned CAP = (MAX_DATAGRAM_BYTES > 65535) ? 65535 : MAX_DATAGRAM_BYTES;
	localparam logic [16:0] CAP17 = 17'(CAP);

	logic [15:0] byte_total_q;
	logic [31:0] header_q;
	logic [31:0] stream_q;
	logic        oui_match_q;
	logic [31:0] class_low_q;

	logic        in_hdr;
	logic [1:0]  pos;
	logic [2:0]  nb;
	logic [16:0] sum;
	logic [15:0] total;
	logic [31:0] header_n;
	logic [31:0] stream_n;
	logic        oui_match_n;
	logic [31:0] class_low_n;

	always_comb begin
		in_hdr = (byte_total_q[15:4] == 12'd0);
		pos    = byte_total_q[3:2];

		header_n    = header_q;
		stream_n    = stream_q;
		oui_match_n = oui_match_q;
		class_low_n = class_low_q;
		if (in_hdr) begin
			case (pos)
				2'd0: header_n = word.data_word;
				2'd1: stream_n = word.data_word;
				2'd2: oui_match_n = (word.data_word[23:0] == vendor_oui);
				default: class_low_n = word.data_word;
			endcase
		end

		if (!word.last) begin
			nb = 3'd4;
		end else if (word.last_bytes > 3'd4) begin
			nb = 3'd4;
		end else begin
			nb = word.last_bytes;
		end
		sum   = {1'b0, byte_total_q} + {14'd0, nb};
		total = (sum > CAP17) ? CAP17[15:0] : sum[15:0];

		push          = accept && word.last;
		rec.total     = total;
		rec.header    = header_n;
		rec.stream    = stream_n;
		rec.oui_match = oui_match_n;
		rec.class_low = class_low_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_total_q <= '0;
			header_q     <= '0;
			stream_q     <= '0;
			oui_match_q  <= 1'b0;
			class_low_q  <= '0;
		end else if (accept) begin
			if (word.last) begin
				byte_total_q <= '0;
				header_q     <= '0;
				stream_q     <= '0;
				oui_match_q  <= 1'b0;
				class_low_q  <= '0;
			end else begin
				byte_total_q <= total;
				header_q     <= header_n;
				stream_q     <= stream_n;
				oui_match_q  <= oui_match_n;
				class_low_q  <= class_low_n;
			end
		end
	end

	`VDHP_ASSERT(a_total_capped, clk, arst_n, {1'b0, byte_total_q} <= CAP17)
	`VDHP_ASSERT_NEXT(a_clear_after_last, clk, arst_n, push, byte_total_q == 16'd0)
	`VDHP_ASSERT_NEXT(a_count_moves, clk, arst_n, accept && !word.last && sum <= CAP17,
		byte_total_q == $past(byte_total_q) + 16'd4)

endmodule

// ===== design/vdhp_queue.sv =====
// ---------------------------------------------------------------------------
// vdhp_queue
// Two-entry queue of datagram records between the front and back ends.
// ---------------------------------------------------------------------------
`include "vita49_data_header_parser_top_defines.svh"

module vdhp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  vdhp_pkg::datagram_rec_t push_rec,
	input  logic                    pop,
	output vdhp_pkg::datagram_rec_t head,
	output vdhp_pkg::queue_stat_t   stat
);

	vdhp_pkg::datagram_rec_t mem_q [vdhp_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_comb begin
		stat.full  = (count_q == 2'(vdhp_pkg::QUEUE_DEPTH));
		stat.empty = (count_q == 2'd0);
		head       = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`VDHP_ASSERT(a_no_overflow, clk, arst_n, !(push && stat.full))
	`VDHP_ASSERT(a_no_underflow, clk, arst_n, !(pop && stat.empty))
	`VDHP_ASSERT(a_ptr_track, clk, arst_n,
		(wr_ptr_q ^ rd_ptr_q) == count_q[0])

endmodule

// ===== design/vdhp_back.sv =====
// ---------------------------------------------------------------------------
// vdhp_back
// Judges one datagram record and holds the verdict in the output register.
// ---------------------------------------------------------------------------
module vdhp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vdhp_pkg::datagram_rec_t rec,
	input  vdhp_pkg::queue_stat_t   qstat,
	input  logic [15:0]             info_class,
	output logic                    pop,
	output logic                    res_valid,
	input  logic                    res_ready,
	output vdhp_pkg::result_t       res
);

	logic              accept_ok;
	logic [4:0]        offset;
	logic [17:0]       declared;
	logic [17:0]       avail;
	logic signed [18:0] payload;
	logic              good;
	vdhp_pkg::result_t verdict;
	logic              valid_q;
	vdhp_pkg::result_t res_q;

	always_comb begin
		accept_ok = (rec.total[15:4] != 12'd0)
			&& ((rec.header & vdhp_pkg::TYPE_MASK) == vdhp_pkg::TYPE_IFSID)
			&& ((rec.header & vdhp_pkg::CLASS_BIT) != 32'd0)
			&& rec.oui_match
			&& (rec.class_low[31:16] == info_class);

		offset = 5'd16;
		if ((rec.header & vdhp_pkg::TSI_MASK) != 32'd0) begin
			offset = offset + 5'd4;
		end
		if ((rec.header & vdhp_pkg::TSF_MASK) != 32'd0) begin
			offset = offset + 5'd8;
		end

		// A declared size of zero falls back to the received size.
		declared = {rec.header[15:0], 2'b00};
		if (declared != 18'd0 && declared < {2'b00, rec.total}) begin
			avail = declared;
		end else begin
			avail = {2'b00, rec.total};
		end

		payload = $signed({1'b0, avail}) - $signed({14'd0, offset});
		if ((rec.header & vdhp_pkg::TRAILER_BIT) != 32'd0) begin
			payload = payload - 19'sd4;
		end
		good = accept_ok && !payload[18] && (payload != 19'sd0);

		verdict = '0;
		if (good) begin
			verdict.valid_res      = 1'b1;
			verdict.stream_id      = rec.stream;
			verdict.packet_class   = rec.class_low[15:0];
			verdict.packet_count   = rec.header[19:16];
			verdict.payload_offset = offset;
			verdict.payload_bytes  = payload[15:0];
		end

		pop       = !qstat.empty && (!valid_q || res_ready);
		res_valid = valid_q;
		res       = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= verdict;
		end
	end

endmodule
